// File: rtl/fsfl_pkg.sv
// Shared types and constants for the fixed-slot free-list allocator.
// No dependencies; imported by every module of the block.
package fsfl_pkg;

  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic REG_SLOT_COUNT = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/fsfl_ctrl.sv
// Controller for the free-list allocator: two-state sequencer.
// Depends on fsfl_pkg.
module fsfl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  fsfl_pkg::dp_status_t sts,
  output fsfl_pkg::ctrl_cmd_t  cmd
);
  import fsfl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_stall   = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/fsfl_dp.sv
// Datapath for the free-list allocator: head register, link memory,
// per-slot written flags and the result register. Depends on fsfl_pkg.
module fsfl_dp #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rebuild,
  input  logic [fsfl_pkg::COUNT_W-1:0]  slot_count,
  input  fsfl_pkg::req_t                req,
  input  fsfl_pkg::ctrl_cmd_t           cmd,
  output fsfl_pkg::dp_status_t          sts,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output fsfl_pkg::rsp_t                rsp
);
  import fsfl_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [IDX_W-1:0] head;
  logic             head_valid;
  logic [IDX_W:0]   mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [IDX_W:0]   rd_data;
  logic             rd_written;
  logic             op;
  logic [SLOT_W-1:0] idx;

  logic [IDX_W:0]   link;
  logic             in_range;
  logic [IDX_W-1:0] wr_addr;
  rsp_t             result;

  assign sts.out_free = !rsp_valid || !rsp_stall;
  assign in_range     = {1'b0, idx} < slot_count;
  assign wr_addr      = idx[IDX_W-1:0];
  assign link         = rd_written ? rd_data : {head != '0, head - IDX_W'(1)};

  always_comb begin
    result = '{status: ST_OK, granted_slot: '0};
    if (op == OP_ALLOC) begin
      if (!head_valid) begin
        result.status = ST_EMPTY;
      end else begin
        result.granted_slot = SLOT_W'(head);
      end
    end else if (!in_range) begin
      result.status = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= req.opcode;
      idx <= req.slot_index;
    end
  end

  always_ff @(posedge clk) begin
    rd_data    <= mem[head];
    rd_written <= written[head];
    if (cmd.commit && op == OP_FREE && in_range) begin
      mem[wr_addr] <= {head_valid, head};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= IDX_W'(DEPTH - 1);
      head_valid <= 1'b1;
      written    <= '0;
    end else if (rebuild) begin
      head       <= IDX_W'(slot_count - COUNT_W'(1));
      head_valid <= 1'b1;
      written    <= '0;
    end else if (cmd.commit) begin
      if (op == OP_ALLOC) begin
        if (head_valid) begin
          head       <= link[IDX_W-1:0];
          head_valid <= link[IDX_W];
        end
      end else if (in_range) begin
        head             <= wr_addr;
        head_valid       <= 1'b1;
        written[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= result;
    end
  end

endmodule

// File: rtl/fixed_slot_free_list_allocator.sv
// Top level of the fixed-slot free-list allocator: APB register and glue.
// Depends on fsfl_pkg, fsfl_ctrl and fsfl_dp.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   req      | req_valid / req_stall  | opcode, slot_index
//   rsp      | rsp_valid / rsp_stall  | status, granted_slot
//   apb      | psel, penable, pready  | paddr, pwdata, prdata
//
// An item is taken in S_IDLE, where the head's link is read from the link
// memory; S_LOOKUP then updates the list and loads the result (req_stall high).
// The result register holds while rsp_stall is high and the next item waits.
// Reset and a slot_count write rebuild the list at once, with no sweep.
module fixed_slot_free_list_allocator #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  fsfl_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output fsfl_pkg::rsp_t               rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsfl_pkg::APB_AW-1:0]  paddr,
  input  logic [fsfl_pkg::APB_DW-1:0]  pwdata,
  output logic [fsfl_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import fsfl_pkg::*;

  localparam int LIMIT = (MAX_SLOTS > 64) ? 64 : MAX_SLOTS;

  logic [COUNT_W-1:0] slot_count, slot_count_next;
  logic [COUNT_W-1:0] wr_val;
  logic               rebuild;
  ctrl_cmd_t          cmd;
  dp_status_t         sts;

  assign pready  = 1'b1;
  assign rebuild = psel && penable && pwrite && paddr[2] == REG_SLOT_COUNT;
  assign wr_val  = pwdata[COUNT_W-1:0];
  assign prdata  = (paddr[2] == REG_SLOT_COUNT) ? APB_DW'(slot_count) : '0;

  always_comb begin
    if (wr_val == '0) begin
      slot_count_next = COUNT_W'(1);
    end else if (wr_val > COUNT_W'(LIMIT)) begin
      slot_count_next = COUNT_W'(LIMIT);
    end else begin
      slot_count_next = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= COUNT_W'(LIMIT);
    end else if (rebuild) begin
      slot_count <= slot_count_next;
    end
  end

  fsfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsfl_dp #(
    .DEPTH (LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .rebuild    (rebuild),
    .slot_count (rebuild ? slot_count_next : slot_count),
    .req        (req),
    .cmd        (cmd),
    .sts        (sts),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule
